// File: hw/rtl/tea_pkg.sv
// Shared types and constants for the TEA block cipher pipeline.
package tea_pkg;

   localparam int unsigned WORD_WIDTH      = 32;
   localparam int unsigned KEY_WORDS       = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9e37_79b9;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD0 = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD1 = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD3 = 2'd3;

   // Direction codes.
   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [WORD_WIDTH-1:0] block_left;
      logic [WORD_WIDTH-1:0] block_right;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] result_left;
      logic [WORD_WIDTH-1:0] result_right;
   } rsp_payload_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] word0;
      logic [WORD_WIDTH-1:0] word1;
      logic [WORD_WIDTH-1:0] word2;
      logic [WORD_WIDTH-1:0] word3;
   } key_type;

   // What travels from one cell to the next.
   typedef struct packed {
      logic                  decrypt;
      logic [WORD_WIDTH-1:0] left;
      logic [WORD_WIDTH-1:0] right;
   } cell_data_type;

   // Running sum after n additions of delta, modulo 2^32.
   function automatic logic [WORD_WIDTH-1:0] tea_round_sum(int unsigned n);
      logic [63:0] prod;
      prod = 64'(TEA_DELTA) * 64'(n);
      return prod[WORD_WIDTH-1:0];
   endfunction

endpackage

// File: hw/rtl/tea_cell.sv
// One half-round cell of the TEA pipeline: updates one half of the block.
module tea_cell
   import tea_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  key_type               keys,
   input  logic [WORD_WIDTH-1:0] sum_enc,
   input  logic [WORD_WIDTH-1:0] sum_dec,
   input  logic                  second_half,
   input  logic                  in_valid,
   input  cell_data_type         in_data,
   output logic                  out_valid,
   output cell_data_type         out_data
);

   logic                  valid_ff, valid_in;
   cell_data_type         data_ff, data_in;
   logic                  upd_left;
   logic [WORD_WIDTH-1:0] src, target, ka, kb, sum, mix, updated;

   always_comb begin
      // Encryption updates left then right; decryption runs the reverse order.
      upd_left = (in_data.decrypt == DIR_DECRYPT) ? second_half : !second_half;
      src      = upd_left ? in_data.right : in_data.left;
      target   = upd_left ? in_data.left  : in_data.right;
      ka       = upd_left ? keys.word0 : keys.word2;
      kb       = upd_left ? keys.word1 : keys.word3;
      sum      = (in_data.decrypt == DIR_DECRYPT) ? sum_dec : sum_enc;
      mix      = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
      updated  = (in_data.decrypt == DIR_DECRYPT) ? (target - mix) : (target + mix);

      valid_in = in_valid;
      data_in  = in_data;
      if (upd_left) begin
         data_in.left = updated;
      end else begin
         data_in.right = updated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: hw/rtl/tea_block_cipher_top.sv
// Top level of the pipelined TEA block cipher with its key registers.
//
// The block encrypts or decrypts one 64-bit block per cycle under a 128-bit key,
// unless the receiver stalls a held result. Every round is split into two half-round
// cells, so a block passes through 2*ROUND_COUNT registered cells before its result
// appears on the response channel. A new block may enter in every cycle unless the
// chain stalls. The last cell is the output register; while it holds a result that
// the receiver stalls, the whole chain and the request side stall with it. Keys are
// written through the csr port, which is always ready, and must only be changed while
// no block is in flight.
module tea_block_cipher_top
   import tea_pkg::*;
#(
   parameter int unsigned ROUND_COUNT = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_wdata
);

   localparam int unsigned STAGES = 2 * ROUND_COUNT;

   key_type       keys_ff, keys_in;
   logic          advance;
   logic          stage_valid [0:STAGES];
   cell_data_type stage_data  [0:STAGES];

   always_comb begin
      keys_in = keys_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_WORD0: keys_in.word0 = csr_wdata;
            CSR_KEY_WORD1: keys_in.word1 = csr_wdata;
            CSR_KEY_WORD2: keys_in.word2 = csr_wdata;
            CSR_KEY_WORD3: keys_in.word3 = csr_wdata;
            default:       keys_in = keys_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign csr_ready = 1'b1;

   // The chain moves as a whole unless a finished result is being held.
   assign advance   = !(stage_valid[STAGES] && rsp_stall);
   assign req_stall = !advance;

   assign stage_valid[0]        = req_valid;
   assign stage_data[0].decrypt = req_payload.req_type;
   assign stage_data[0].left    = req_payload.block_left;
   assign stage_data[0].right   = req_payload.block_right;

   for (genvar s = 0; s < STAGES; s++) begin : g_cell
      localparam int unsigned ROUND = s / 2;
      tea_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .keys        (keys_ff),
         .sum_enc     (tea_round_sum(ROUND + 1)),
         .sum_dec     (tea_round_sum(ROUND_COUNT - ROUND)),
         .second_half (1'((s % 2) != 0)),
         .in_valid    (stage_valid[s]),
         .in_data     (stage_data[s]),
         .out_valid   (stage_valid[s+1]),
         .out_data    (stage_data[s+1])
      );
   end

   assign rsp_valid                = stage_valid[STAGES];
   assign rsp_payload.result_left  = stage_data[STAGES].left;
   assign rsp_payload.result_right = stage_data[STAGES].right;

endmodule

// File: hw/rtl/tea_checker.sv
// Port-level checks for the TEA block cipher top level, bound to it.
module tea_checker
   import tea_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // A stalled result stays and keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Reset empties the chain.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Backpressure on the request side comes only from a held result.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow the result side");

   // An empty output register never blocks a new transfer.
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with no result pending");

endmodule

bind tea_block_cipher_top tea_checker u_tea_checker (.*);

// File: tb/tb_tea_block_cipher_top.sv
// Testbench for the pipelined TEA block cipher: directed and random traffic checked against a software cipher.
module tb_tea_block_cipher_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tea_pkg::*;

   localparam int unsigned ROUNDS = 32;
   localparam int unsigned PIPE_DEPTH = 2 * ROUNDS;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned PHASE_BLOCKS = 165;

   // Keeps its own copy of the key and the expected results of the blocks still in flight.
   class tea_scoreboard;
      key_type         key;
      rsp_payload_type due_blocks[$];
      int unsigned     mismatches;

      function new();
         key = '0;
         mismatches = 0;
      endfunction

      function void write_key(logic [CSR_INDEX_WIDTH-1:0] index, logic [WORD_WIDTH-1:0] data);
         case (index)
            CSR_KEY_WORD0: key.word0 = data;
            CSR_KEY_WORD1: key.word1 = data;
            CSR_KEY_WORD2: key.word2 = data;
            CSR_KEY_WORD3: key.word3 = data;
            default: ;
         endcase
      endfunction

      function logic [WORD_WIDTH-1:0] mix(logic [WORD_WIDTH-1:0] x, logic [WORD_WIDTH-1:0] sum,
                                          logic [WORD_WIDTH-1:0] ka, logic [WORD_WIDTH-1:0] kb);
         return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
      endfunction

      function rsp_payload_type cipher(req_payload_type blk);
         logic [WORD_WIDTH-1:0] a;
         logic [WORD_WIDTH-1:0] b;
         logic [WORD_WIDTH-1:0] sum;
         rsp_payload_type       res;
         a = blk.block_left;
         b = blk.block_right;
         sum = '0;
         if (blk.req_type == DIR_DECRYPT) begin
            // Decryption starts from the sum that encryption ends with.
            for (int n = 0; n < ROUNDS; n++) sum += TEA_DELTA;
            for (int n = 0; n < ROUNDS; n++) begin
               b -= mix(a, sum, key.word2, key.word3);
               a -= mix(b, sum, key.word0, key.word1);
               sum -= TEA_DELTA;
            end
         end else begin
            for (int n = 0; n < ROUNDS; n++) begin
               sum += TEA_DELTA;
               a += mix(b, sum, key.word0, key.word1);
               b += mix(a, sum, key.word2, key.word3);
            end
         end
         res.result_left = a;
         res.result_right = b;
         return res;
      endfunction

      function void note_block(req_payload_type blk);
         due_blocks.push_back(cipher(blk));
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (due_blocks.size() == 0) begin
            $error("unexpected result %016h with no block in flight", got);
            mismatches++;
            return;
         end
         want = due_blocks.pop_front();
         if (got.result_left !== want.result_left) begin
            $error("result_left: expected %08h, actual %08h", want.result_left, got.result_left);
            mismatches++;
         end
         if (got.result_right !== want.result_right) begin
            $error("result_right: expected %08h, actual %08h", want.result_right,
                   got.result_right);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return due_blocks.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_payload_type            req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_payload_type            rsp_payload;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [WORD_WIDTH-1:0]      csr_wdata;

   int unsigned   send_idle_pct = 26;
   int unsigned   recv_idle_pct = 66;
   int unsigned   quiet_cycles = 0;
   tea_scoreboard sb = new();

   tea_block_cipher_top #(.ROUND_COUNT(ROUNDS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Every transfer is observed here; the watchdog trips when nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_key(csr_index, csr_wdata);
         if (req_valid && !req_stall) sb.note_block(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
         if ((csr_valid && csr_ready) || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic logic [WORD_WIDTH-1:0] random_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type random_block();
      req_payload_type blk;
      blk.req_type = $urandom_range(1) ? DIR_DECRYPT : DIR_ENCRYPT;
      blk.block_left = random_word();
      blk.block_right = random_word();
      return blk;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer with valid high.
   task automatic send_block(input req_payload_type blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= blk;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [WORD_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   task automatic load_key(input key_type k);
      wait_drained();
      write_csr(CSR_KEY_WORD0, k.word0);
      write_csr(CSR_KEY_WORD1, k.word1);
      write_csr(CSR_KEY_WORD2, k.word2);
      write_csr(CSR_KEY_WORD3, k.word3);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input key_type k);
      load_key(k);
      repeat (PHASE_BLOCKS) send_block(random_block());
      req_valid <= 1'b0;
   endtask

   task automatic send_directed();
      logic [WORD_WIDTH-1:0] lefts[6];
      logic [WORD_WIDTH-1:0] rights[6];
      req_payload_type       blk;
      lefts = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1};
      rights = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h8000_0000};
      for (int d = 0; d < 2; d++) begin
         for (int i = 0; i < 6; i++) begin
            blk.req_type = (d == 0) ? DIR_ENCRYPT : DIR_DECRYPT;
            blk.block_left = lefts[i];
            blk.block_right = rights[i];
            send_block(blk);
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = CSR_KEY_WORD0;
      csr_wdata = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed blocks run under the all-zero key left by reset.
      send_directed();
      run_phase('1);
      run_phase('{$urandom, $urandom, $urandom, $urandom});

      send_idle_pct = 66;
      recv_idle_pct = 26;
      run_phase('0);
      run_phase('{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000});

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase('{$urandom, $urandom, $urandom, $urandom});
      run_phase('{32'hFFFF_FFFF, 32'h0, $urandom, 32'hFFFF_FFFF});

      wait_drained();
      repeat (PIPE_DEPTH + 8) @(negedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (sb.outstanding() != 0) $error("%0d results never arrived", sb.outstanding());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
